### rtl/htok_pkg.sv
// ----------------------------------------------------------------------------
// htok_pkg - shared types and constants for the HTTP request byte tokeniser
// Beat structs, parse phases, token kinds, delimiter characters and the
// Content-Length key table.
// ----------------------------------------------------------------------------
package htok_pkg;

   // Default width of the parsed body length
   localparam int LENGTH_BITS_DEF = 32;

   // Header key that carries the body length, and its special match indexes
   localparam int         KEY_CHARS  = 14;
   localparam logic [3:0] KEY_LEN    = 4'd14;
   localparam logic [3:0] KEY_DIGITS = 4'd15;

   // Token kinds
   localparam logic [3:0] KIND_DELIM  = 4'd0;
   localparam logic [3:0] KIND_METHOD = 4'd1;
   localparam logic [3:0] KIND_URL    = 4'd2;
   localparam logic [3:0] KIND_QKEY   = 4'd3;
   localparam logic [3:0] KIND_QVAL   = 4'd4;
   localparam logic [3:0] KIND_VER    = 4'd5;
   localparam logic [3:0] KIND_HKEY   = 4'd6;
   localparam logic [3:0] KIND_HVAL   = 4'd7;
   localparam logic [3:0] KIND_BODY   = 4'd8;

   // Characters of interest
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // Parse phases
   typedef enum logic [3:0] {
      PH_METHOD,
      PH_URL,
      PH_QKEY,
      PH_QVAL,
      PH_VERSION,
      PH_HKEY,
      PH_HVAL,
      PH_BODY,
      PH_DONE
   } phase_type;

   // Input beat
   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_request;
   } req_beat_type;

   // Result beat
   typedef struct packed {
      logic [7:0]  byte_out;
      logic [3:0]  kind;
      logic        pair_end;
      logic        query_present;
      logic [31:0] content_length;
      logic        request_done;
      logic        format_error;
   } rsp_beat_type;

   // Handshake between the input register and the result register
   typedef struct packed {
      logic valid;   // input register holds a beat
      logic step;    // beat moves on into the result register this cycle
   } stage_ctl_type;

   // Characters of "Content-Length", by match index
   function automatic logic [7:0] len_key_char(input logic [3:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0:    ch = 8'h43; // C
         4'd1:    ch = 8'h6F; // o
         4'd2:    ch = 8'h6E; // n
         4'd3:    ch = 8'h74; // t
         4'd4:    ch = 8'h65; // e
         4'd5:    ch = 8'h6E; // n
         4'd6:    ch = 8'h74; // t
         4'd7:    ch = 8'h2D; // -
         4'd8:    ch = 8'h4C; // L
         4'd9:    ch = 8'h65; // e
         4'd10:   ch = 8'h6E; // n
         4'd11:   ch = 8'h67; // g
         4'd12:   ch = 8'h74; // t
         4'd13:   ch = 8'h68; // h
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

### rtl/htok_in_reg.sv
// ----------------------------------------------------------------------------
// htok_in_reg - input register
// Captures one request beat and holds it until the result register is free.
// ----------------------------------------------------------------------------
module htok_in_reg
   import htok_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_beat_type  req_data,
   input  logic          out_free,
   output stage_ctl_type ctl,
   output req_beat_type  beat
);

   logic         valid_ff;
   logic         valid_in;
   req_beat_type data_ff;
   logic         load;

   // A held beat moves on whenever the result register can take it
   assign ctl.valid = valid_ff;
   assign ctl.step  = valid_ff & out_free;
   assign req_stall = valid_ff & ~out_free;
   assign load      = ~valid_ff | out_free;
   assign valid_in  = load ? req_valid : valid_ff;
   assign beat      = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         data_ff <= req_data;
      end
   end

endmodule

### rtl/htok_core.sv
// ----------------------------------------------------------------------------
// htok_core - parse state and byte classification
// Holds the parse state and works out the tag and flags of one beat.
// ----------------------------------------------------------------------------
module htok_core
   import htok_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_beat_type beat,
   output rsp_beat_type result
);

   localparam int LB = LENGTH_BITS;

   // State registers
   phase_type       phase_ff,     phase_in;
   logic [3:0]      key_idx_ff,   key_idx_in;
   logic            key_mis_ff,   key_mis_in;
   logic            len_seen_ff,  len_seen_in;
   logic [LB-1:0]   len_val_ff,   len_val_in;
   logic [LB-1:0]   body_cnt_ff,  body_cnt_in;
   logic            query_ff,     query_in;
   logic            error_ff,     error_in;

   // Current state after an optional start of request
   phase_type       cur_phase;
   logic [3:0]      cur_key_idx;
   logic            cur_key_mis;
   logic            cur_len_seen;
   logic [LB-1:0]   cur_len_val;
   logic [LB-1:0]   cur_body_cnt;
   logic            cur_query;
   logic            cur_error;

   logic [7:0]      b;
   logic [3:0]      kind;
   logic            pend;
   logic            key_ok;
   logic [3:0]      digit;
   logic [LB+3:0]   len_x10;
   logic [LB:0]     body_next;
   logic [LB+31:0]  len_ext;

   assign b = beat.data_byte;

   // Decimal accumulate: 10*L + d, overflow when anything lands above LB bits
   assign digit   = 4'(b - CH_ZERO);
   assign len_x10 = {1'b0, cur_len_val, 3'b000} + {3'b000, cur_len_val, 1'b0}
                    + {{LB{1'b0}}, digit};
   assign body_next = {1'b0, cur_body_cnt} + {{LB{1'b0}}, 1'b1};
   assign key_ok    = ~cur_key_mis & (cur_key_idx >= KEY_LEN);

   always_comb begin
      // start of request clears everything before the byte is handled
      if (beat.start_of_request) begin
         cur_phase    = PH_METHOD;
         cur_key_idx  = 4'd0;
         cur_key_mis  = 1'b0;
         cur_len_seen = 1'b0;
         cur_len_val  = '0;
         cur_body_cnt = '0;
         cur_query    = 1'b0;
         cur_error    = 1'b0;
      end else begin
         cur_phase    = phase_ff;
         cur_key_idx  = key_idx_ff;
         cur_key_mis  = key_mis_ff;
         cur_len_seen = len_seen_ff;
         cur_len_val  = len_val_ff;
         cur_body_cnt = body_cnt_ff;
         cur_query    = query_ff;
         cur_error    = error_ff;
      end
   end

   // Next state and byte tag
   always_comb begin
      phase_in    = cur_phase;
      key_idx_in  = cur_key_idx;
      key_mis_in  = cur_key_mis;
      len_seen_in = cur_len_seen;
      len_val_in  = cur_len_val;
      body_cnt_in = cur_body_cnt;
      query_in    = cur_query;
      error_in    = cur_error;
      kind        = KIND_DELIM;
      pend        = 1'b0;

      unique case (cur_phase)
         PH_METHOD: begin
            if (b == CH_SPACE) phase_in = PH_URL;
            else               kind     = KIND_METHOD;
         end
         PH_URL: begin
            if (b == CH_QMARK) begin
               query_in = 1'b1;
               phase_in = PH_QKEY;
            end else if (b == CH_SPACE) begin
               phase_in = PH_VERSION;
            end else begin
               kind = KIND_URL;
            end
         end
         PH_QKEY: begin
            if (b == CH_EQ)         phase_in = PH_QVAL;
            else if (b == CH_SPACE) phase_in = PH_VERSION;
            else                    kind     = KIND_QKEY;
         end
         PH_QVAL: begin
            if (b == CH_AMP) begin
               pend     = 1'b1;
               phase_in = PH_QKEY;
            end else if (b == CH_SPACE) begin
               pend     = 1'b1;
               phase_in = PH_VERSION;
            end else begin
               kind = KIND_QVAL;
            end
         end
         PH_VERSION: begin
            if (b == CH_LF) begin
               key_idx_in = 4'd0;
               key_mis_in = 1'b0;
               phase_in   = PH_HKEY;
            end else if (b != CH_CR) begin
               kind = KIND_VER;
            end
         end
         PH_HKEY: begin
            if (b == CH_LF) begin
               // blank line: body only with a good, nonzero length
               if (cur_error || !cur_len_seen || cur_len_val == '0) phase_in = PH_DONE;
               else                                                  phase_in = PH_BODY;
            end else if (b == CH_SPACE) begin
               phase_in = PH_HVAL;
            end else if (b != CH_CR && b != CH_COLON) begin
               kind = KIND_HKEY;
               if (!cur_key_mis) begin
                  if (cur_key_idx < KEY_LEN && b == len_key_char(cur_key_idx))
                     key_idx_in = cur_key_idx + 4'd1;
                  else
                     key_mis_in = 1'b1;
               end
            end
         end
         PH_HVAL: begin
            if (b == CH_LF) begin
               pend = 1'b1;
               if (key_ok && !cur_len_seen) begin
                  if (cur_key_idx != KEY_DIGITS) error_in = 1'b1;
                  len_seen_in = 1'b1;
               end
               key_idx_in = 4'd0;
               key_mis_in = 1'b0;
               phase_in   = PH_HKEY;
            end else if (b != CH_CR) begin
               kind = KIND_HVAL;
               if (key_ok && !cur_len_seen) begin
                  if (b >= CH_ZERO && b <= CH_NINE) begin
                     key_idx_in = KEY_DIGITS;
                     if (len_x10[LB+3:LB] != 4'd0) begin
                        // saturate on overflow
                        error_in   = 1'b1;
                        len_val_in = '1;
                     end else begin
                        len_val_in = len_x10[LB-1:0];
                     end
                  end else begin
                     error_in = 1'b1;
                  end
               end
            end
         end
         PH_BODY: begin
            kind        = KIND_BODY;
            body_cnt_in = body_next[LB-1:0];
            if (body_next >= {1'b0, cur_len_val}) phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   // Result fields from the updated state
   assign len_ext = {32'd0, len_val_in};

   always_comb begin
      result.byte_out       = b;
      result.kind           = kind;
      result.pair_end       = pend;
      result.query_present  = query_in;
      result.content_length = len_seen_in ? len_ext[31:0] : 32'd0;
      result.request_done   = (phase_in == PH_DONE);
      result.format_error   = error_in;
   end

   // State update, one beat per step
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_METHOD;
         key_idx_ff  <= 4'd0;
         key_mis_ff  <= 1'b0;
         len_seen_ff <= 1'b0;
         len_val_ff  <= '0;
         body_cnt_ff <= '0;
         query_ff    <= 1'b0;
         error_ff    <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         key_idx_ff  <= key_idx_in;
         key_mis_ff  <= key_mis_in;
         len_seen_ff <= len_seen_in;
         len_val_ff  <= len_val_in;
         body_cnt_ff <= body_cnt_in;
         query_ff    <= query_in;
         error_ff    <= error_in;
      end
   end

endmodule

### rtl/http_request_byte_tokenizer_top.sv
// ----------------------------------------------------------------------------
// http_request_byte_tokenizer_top - HTTP request byte tokeniser
// Tags every byte of an HTTP request and tracks the Content-Length body.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one request byte per beat, with start_of_request set on the
//   first byte of a new request to clear the parse state.
//   rsp_ channel: one result beat per request beat, in order, carrying the
//   byte, its token kind, pair end, query flag, parsed length, done and error.
// Path: a request beat is captured in the input register, then tagged by the
//   classification logic and captured in the result register.
// Throughput: one beat per cycle while rsp_ is not stalled; the parse state is a
//   single loop through the classification logic, closed once per beat.
// Reset: synchronous; clears both stage valids and the parse state back to
//   the method phase. No memories, so no clearing pass.
// Stall: while rsp_stall holds a shown beat, the input register still takes
//   one more beat; req_stall rises only once that register is full too.
// ----------------------------------------------------------------------------
module http_request_byte_tokenizer_top
   import htok_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_beat_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_beat_type rsp_data
);

   stage_ctl_type ctl;
   req_beat_type  beat;
   rsp_beat_type  result;
   logic          out_free;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_beat_type  rsp_data_ff;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   htok_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_free  (out_free),
      .ctl       (ctl),
      .beat      (beat)
   );

   htok_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (ctl.step),
      .beat   (beat),
      .result (result)
   );

   // Result register
   assign rsp_valid_in = out_free ? ctl.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/htok_checker.sv
// ----------------------------------------------------------------------------
// htok_checker - port-level checks for the tokeniser
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module htok_checker
   import htok_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_beat_type rsp_data
);

   // A stalled result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // Nothing shown in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // With the result register empty the input side never stalls
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

   // A closing byte is a delimiter, never a tagged byte
   a_pair_delim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pair_end |-> rsp_data.kind == KIND_DELIM)
      else $error("pair end on a tagged byte");

   // Once done, a byte is either the last body byte or ignored
   a_done_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.request_done |->
         rsp_data.kind == KIND_DELIM || rsp_data.kind == KIND_BODY)
      else $error("tagged byte after request end");

endmodule

bind http_request_byte_tokenizer_top htok_checker u_htok_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
